@@ src/leb_pkg.sv @@
`timescale 1ns / 1ps

package leb_pkg;

    localparam int LEB_WIDTH = 32;
    localparam logic [63:0] LEB_MASK = {64{1'b1}} >> (64 - LEB_WIDTH);
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [3:0] {
        K_ULEB   = 4'd0,
        K_ULEBM1 = 4'd1,
        K_SLEB   = 4'd2,
        K_U64    = 4'd3,
        K_S64    = 4'd4,
        K_U32    = 4'd5,
        K_S32    = 4'd6,
        K_U16    = 4'd7,
        K_S16    = 4'd8,
        K_U8     = 4'd9,
        K_S8     = 4'd10
    } t_kind;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic [3:0] idx;
        logic       order;
        logic       fin;
        logic       trunc;
    } t_cmd;

    function automatic logic [3:0] fixed_bytes(input t_kind kind);
        logic [3:0] n;
        case (kind)
            K_U64, K_S64: n = 4'd8;
            K_U32, K_S32: n = 4'd4;
            K_U16, K_S16: n = 4'd2;
            default:      n = 4'd1;
        endcase
        return n;
    endfunction

endpackage

@@ src/leb_if.sv @@
`timescale 1ns / 1ps

interface leb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [3:0] mode;
    logic       region_end;

    modport source (output valid, data_byte, mode, region_end, input ready);
    modport sink (input valid, data_byte, mode, region_end, output ready);
endinterface

interface leb_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        truncated;

    modport source (output valid, value, truncated, input ready);
    modport sink (input valid, value, truncated, output ready);
endinterface

@@ src/leb_front.sv @@
`timescale 1ns / 1ps

module leb_front
    import leb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic [3:0] i_mode,
    input  logic       i_region_end,
    input  logic       i_byte_order,
    input  logic       i_q_full,
    output logic       o_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic       r_in_field;
    logic       n_in_field;
    t_kind      r_kind;
    t_kind      n_kind;
    logic [3:0] r_idx;
    logic [3:0] n_idx;

    logic       accept;
    logic       drop;
    t_kind      kind;
    logic [3:0] idx;
    logic       done;
    logic       fin;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        kind = r_in_field ? r_kind : t_kind'(i_mode);
        idx  = r_in_field ? r_idx : 4'd0;
        drop = !r_in_field && (i_mode > K_S8);
        if (kind <= K_SLEB) begin
            done = !i_data_byte[7];
        end else begin
            done = (5'(idx) + 5'd1) >= 5'(fixed_bytes(kind));
        end
        fin = done || i_region_end;

        o_push        = accept && !drop;
        o_cmd.data    = i_data_byte;
        o_cmd.kind    = kind;
        o_cmd.idx     = idx;
        o_cmd.order   = i_byte_order;
        o_cmd.fin     = fin;
        o_cmd.trunc   = !done && i_region_end;

        n_in_field = r_in_field;
        n_kind     = r_kind;
        n_idx      = r_idx;
        if (o_push) begin
            n_kind = kind;
            if (fin) begin
                n_in_field = 1'b0;
                n_idx      = 4'd0;
            end else begin
                n_in_field = 1'b1;
                n_idx      = (idx == 4'd15) ? idx : idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_field <= 1'b0;
            r_kind     <= K_ULEB;
            r_idx      <= 4'd0;
        end else begin
            r_in_field <= n_in_field;
            r_kind     <= n_kind;
            r_idx      <= n_idx;
        end
    end

endmodule

@@ src/leb_queue.sv @@
`timescale 1ns / 1ps

module leb_queue
    import leb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = r_count == (QPTR_W + 1)'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

@@ src/leb_back.sv @@
`timescale 1ns / 1ps

module leb_back
    import leb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_valid,
    output logic [63:0] o_value,
    output logic        o_truncated,
    input  logic        i_ready
);

    logic [63:0] r_acc;
    logic [63:0] n_acc;
    logic        r_out_valid;
    logic [63:0] r_out_value;
    logic        r_out_trunc;

    logic [6:0]  shift;
    logic [6:0]  top;
    logic [63:0] filled;
    logic [63:0] sleb;
    logic [63:0] result;

    assign o_pop       = i_valid && (!i_cmd.fin || !r_out_valid || i_ready);
    assign o_valid     = r_out_valid;
    assign o_value     = r_out_value;
    assign o_truncated = r_out_trunc;

    always_comb begin
        shift  = 7'(i_cmd.idx) * 7'd7;
        top    = shift + 7'd7;
        n_acc  = r_acc;
        filled = '0;
        sleb   = '0;
        result = '0;
        if (i_cmd.kind <= K_SLEB) begin
            if (shift < 7'(LEB_WIDTH)) begin
                n_acc = (r_acc | (64'(i_cmd.data[6:0]) << shift)) & LEB_MASK;
            end
            filled = (top >= 7'(LEB_WIDTH)) ? LEB_MASK : ~({64{1'b1}} << top);
            sleb   = n_acc | (i_cmd.data[6] ? (LEB_MASK & ~filled) : 64'd0);
            sleb   = sleb | (sleb[LEB_WIDTH-1] ? ~LEB_MASK : 64'd0);
            case (i_cmd.kind)
                K_ULEB:   result = n_acc;
                K_ULEBM1: result = (n_acc - 64'd1) & LEB_MASK;
                default:  result = sleb;
            endcase
        end else begin
            if (i_cmd.order) begin
                n_acc = {r_acc[55:0], i_cmd.data};
            end else begin
                n_acc = r_acc | (64'(i_cmd.data) << {i_cmd.idx[2:0], 3'b000});
            end
            case (i_cmd.kind)
                K_U64, K_S64: result = n_acc;
                K_U32:        result = {32'd0, n_acc[31:0]};
                K_S32:        result = {{32{n_acc[31]}}, n_acc[31:0]};
                K_U16:        result = {48'd0, n_acc[15:0]};
                K_S16:        result = {{48{n_acc[15]}}, n_acc[15:0]};
                K_U8:         result = {56'd0, n_acc[7:0]};
                default:      result = {{56{n_acc[7]}}, n_acc[7:0]};
            endcase
        end
        if (i_cmd.trunc) begin
            result = (i_cmd.kind == K_ULEBM1) ? LEB_MASK : 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_acc <= i_cmd.fin ? 64'd0 : n_acc;
            end
            if (o_pop && i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.fin) begin
            r_out_value <= result;
            r_out_trunc <= i_cmd.trunc;
        end
    end

endmodule

@@ src/leb128_and_fixed_field_decoder.sv @@
`timescale 1ns / 1ps

// Decodes a byte stream into LEB128 fields (unsigned, unsigned minus one,
// signed) and fixed 8- to 64-bit fields, taking one byte per cycle while the
// command queue has room. The mode is read on the first byte of each field;
// unknown modes on a first byte are dropped. A field cut off by region_end
// yields zero (all ones over the LEB width for the minus-one kind) with
// truncated set. Accepted bytes are written into the command queue; the back
// accumulator registers a field's result onto the output on popping its last
// byte. The input stays ready while the four-item command queue between the
// front classifier and the back accumulator has room, so a stalled output
// holds back the input only once the queue is full. The byte_order register
// is sampled per byte and may only be written while the block is idle.
module leb128_and_fixed_field_decoder
    import leb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    leb_in_if.sink    i_in,
    leb_out_if.source o_out
);

    logic r_byte_order;
    logic q_full;
    logic push;
    t_cmd push_cmd;
    logic pop;
    logic q_valid;
    t_cmd q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_order <= 1'b0;
        end else if (i_cfg_we) begin
            r_byte_order <= i_cfg_wdata;
        end
    end

    leb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .i_data_byte  (i_in.data_byte),
        .i_mode       (i_in.mode),
        .i_region_end (i_in.region_end),
        .i_byte_order (r_byte_order),
        .i_q_full     (q_full),
        .o_ready      (i_in.ready),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    leb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    leb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_valid     (o_out.valid),
        .o_value     (o_out.value),
        .o_truncated (o_out.truncated),
        .i_ready     (o_out.ready)
    );

endmodule

@@ src/leb_chk.sv @@
`timescale 1ns / 1ps

module leb_chk
    import leb_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_value,
    input logic        i_out_truncated
);

    // A result that is not taken stays on the output.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped while stalled");

    // A truncated field only ever reports zero or the LEB width mask.
    a_trunc_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_truncated |-> i_out_value == 64'd0 || i_out_value == LEB_MASK)
        else $error("truncated item carries a bad value");

    // The input only backs up after the output was stalled.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> $past(i_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    // Reset leaves an empty pipeline that accepts input.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not empty after reset");

endmodule

bind leb128_and_fixed_field_decoder leb_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_value     (o_out.value),
    .i_out_truncated (o_out.truncated)
);
